@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the probe sweep level measure RTL.
// Each macro expects clk in scope; ASSERT_RST also expects rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, masked while reset is asserted.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Concurrent assertion that holds through reset as well.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

@@ src/psl_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psl_pkg
// Widths, codes and shared types of the probe sweep level measure block.
// ---------------------------------------------------------------------------
package psl_pkg;

    localparam int ANGLE_W    = 12;
    localparam int STEP_W     = 8;
    localparam int ADC_W      = 10;
    localparam int SUM_W      = 16;
    localparam int OUTCOME_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam int TOUCH_COUNT_DEF = 4;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX_CODE = '1;

    // Input function codes
    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Outcome codes
    localparam logic [OUTCOME_W-1:0] OUTCOME_MEASURED   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_NO_SURFACE = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_TOP_TOUCH  = 2'd2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOME_ANGLE      = 3'd0,
        REG_MAX_ANGLE       = 3'd1,
        REG_WASH_STEP       = 3'd2,
        REG_SEARCH_STEP     = 3'd3,
        REG_BACKOFF_STEP    = 3'd4,
        REG_TOUCH_THRESHOLD = 3'd5
    } reg_index_t;

    // Reset values of the configuration registers
    localparam logic [ANGLE_W-1:0] HOME_ANGLE_RST      = 12'd0;
    localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST       = 12'd2880;
    localparam logic [STEP_W-1:0]  WASH_STEP_RST       = 8'd16;
    localparam logic [STEP_W-1:0]  SEARCH_STEP_RST     = 8'd8;
    localparam logic [ANGLE_W-1:0] BACKOFF_STEP_RST    = 12'd160;
    localparam logic [ADC_W-1:0]   TOUCH_THRESHOLD_RST = 10'd600;

    typedef struct packed {
        logic [ANGLE_W-1:0] home_angle;
        logic [ANGLE_W-1:0] max_angle;
        logic [STEP_W-1:0]  wash_step;
        logic [STEP_W-1:0]  search_step;
        logic [ANGLE_W-1:0] backoff_step;
        logic [ADC_W-1:0]   touch_threshold;
    } cfg_t;

    // Sequencer to statistics unit
    typedef struct packed {
        logic               clear;
        logic               record;
        logic [ANGLE_W-1:0] angle;
    } stats_ctrl_t;

    // Statistics unit to sequencer
    typedef struct packed {
        logic               last_touch;
        logic [ANGLE_W-1:0] level;
        logic [ANGLE_W-1:0] spread;
    } stats_stat_t;

    typedef struct packed {
        logic [ANGLE_W-1:0]   probe_angle;
        logic                 servo_on;
        logic                 done_res;
        logic [OUTCOME_W-1:0] outcome;
        logic [ANGLE_W-1:0]   level;
        logic [ANGLE_W-1:0]   spread;
    } result_t;

endpackage

@@ src/psl_item_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psl_item_if
// Input channel: start commands and sensor samples.
// ---------------------------------------------------------------------------
interface psl_item_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [psl_pkg::ADC_W-1:0]   adc_sample;

    modport source (output valid, output func, output adc_sample, input ready);
    modport sink   (input valid, input func, input adc_sample, output ready);
endinterface

@@ src/psl_result_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psl_result_if
// Output channel: one result per accepted item.
// ---------------------------------------------------------------------------
interface psl_result_if;
    logic                            valid;
    logic                            ready;
    logic [psl_pkg::ANGLE_W-1:0]     probe_angle;
    logic                            servo_on;
    logic                            done_res;
    logic [psl_pkg::OUTCOME_W-1:0]   outcome;
    logic [psl_pkg::ANGLE_W-1:0]     level;
    logic [psl_pkg::ANGLE_W-1:0]     spread;

    modport source (output valid, output probe_angle, output servo_on, output done_res,
                    output outcome, output level, output spread, input ready);
    modport sink   (input valid, input probe_angle, input servo_on, input done_res,
                    input outcome, input level, input spread, output ready);
endinterface

@@ src/psl_stats.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psl_stats
// Touch statistics: count, running sum, min and max of recorded angles.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module psl_stats #(
    parameter int TOUCH_COUNT = psl_pkg::TOUCH_COUNT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psl_pkg::stats_ctrl_t  ctrl,
    output psl_pkg::stats_stat_t  stat
);
    import psl_pkg::*;

    localparam int CNT_W = $clog2(TOUCH_COUNT + 1);
    // Mean by reciprocal multiply, exact for every SUM_W-bit sum
    localparam int SHIFT = SUM_W + $clog2(TOUCH_COUNT);
    localparam longint unsigned RECIP_L =
        ((longint'(1) << SHIFT) + longint'(TOUCH_COUNT) - 1) / longint'(TOUCH_COUNT);
    localparam logic [SUM_W:0] RECIP = RECIP_L[SUM_W:0];
    localparam int PROD_W = 2 * SUM_W + 1;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [ANGLE_W-1:0] min_reg, min_next;
    logic [ANGLE_W-1:0] max_reg, max_next;

    logic [CNT_W:0]     count_inc;
    logic [SUM_W-1:0]   sum_rec;
    logic [ANGLE_W-1:0] min_rec, max_rec;
    logic [PROD_W-1:0]  product;
    logic [PROD_W-1:0]  quotient;

    always_comb
    begin
        count_inc = {1'b0, count_reg} + (CNT_W+1)'(1);
        sum_rec   = sum_reg + SUM_W'(ctrl.angle);
        min_rec   = (ctrl.angle < min_reg) ? ctrl.angle : min_reg;
        max_rec   = (ctrl.angle > max_reg) ? ctrl.angle : max_reg;

        count_next = count_reg;
        sum_next   = sum_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
            sum_next   = '0;
            min_next   = ANGLE_MAX_CODE;
            max_next   = '0;
        end
        else if (ctrl.record)
        begin
            count_next = count_inc[CNT_W-1:0];
            sum_next   = sum_rec;
            min_next   = min_rec;
            max_next   = max_rec;
        end

        // Figures as they stand once the current touch is recorded
        product  = PROD_W'(sum_rec) * PROD_W'(RECIP);
        quotient = product >> SHIFT;

        stat.last_touch = count_inc >= (CNT_W+1)'(TOUCH_COUNT);
        stat.level      = quotient[ANGLE_W-1:0];
        stat.spread     = max_rec - min_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            min_reg   <= ANGLE_MAX_CODE;
            max_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

    `ASSERT_ALWAYS(a_min_le_max, (count_reg != '0) |-> (min_reg <= max_reg), "min above max")
    `ASSERT_RST(a_count_bound, count_reg <= CNT_W'(TOUCH_COUNT), "touch count overrun")

endmodule

@@ src/psl_seq.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psl_seq
// Sweep sequencer: phase, sweep angle and commanded angle; builds results.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module psl_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic                        func,
    input  logic [psl_pkg::ADC_W-1:0]   adc_sample,
    input  psl_pkg::cfg_t               cfg,
    input  psl_pkg::stats_stat_t        stat,
    output psl_pkg::stats_ctrl_t        ctrl,
    output psl_pkg::result_t            res
);
    import psl_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WASH,
        PH_CHECK,
        PH_SEARCH
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [ANGLE_W-1:0] angle_reg, angle_next;
    logic [ANGLE_W-1:0] cmd_angle_reg, cmd_angle_next;

    logic               touch;
    logic               over_max;
    logic [ANGLE_W-1:0] backed;
    logic [STEP_W-1:0]  adv_step;
    logic [ANGLE_W:0]   adv_sum;
    logic [ANGLE_W-1:0] advanced;
    logic               done;
    logic [OUTCOME_W-1:0] code;
    logic               report;
    logic               clear;
    logic               record;

    always_comb
    begin
        touch    = adc_sample > cfg.touch_threshold;
        over_max = angle_reg > cfg.max_angle;
        backed   = (angle_reg > cfg.backoff_step) ? (angle_reg - cfg.backoff_step) : '0;
        adv_step = (phase_reg == PH_WASH) ? cfg.wash_step : cfg.search_step;
        adv_sum  = {1'b0, angle_reg} + (ANGLE_W+1)'(adv_step);
        advanced = adv_sum[ANGLE_W] ? ANGLE_MAX_CODE : adv_sum[ANGLE_W-1:0];

        phase_next     = phase_reg;
        angle_next     = angle_reg;
        cmd_angle_next = cmd_angle_reg;
        done           = 1'b0;
        code           = OUTCOME_MEASURED;
        report         = 1'b0;
        clear          = 1'b0;
        record         = 1'b0;

        if (func == FUNC_START)
        begin
            phase_next     = PH_WASH;
            angle_next     = cfg.home_angle;
            cmd_angle_next = cfg.home_angle;
            clear          = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                PH_WASH, PH_SEARCH:
                begin
                    if (touch)
                    begin
                        record = (phase_reg == PH_SEARCH);
                        if (record && stat.last_touch)
                        begin
                            done   = 1'b1;
                            code   = OUTCOME_MEASURED;
                            report = 1'b1;
                        end
                        else
                        begin
                            phase_next     = PH_CHECK;
                            angle_next     = backed;
                            cmd_angle_next = backed;
                        end
                    end
                    else if (over_max)
                    begin
                        done = 1'b1;
                        code = OUTCOME_NO_SURFACE;
                    end
                    else
                    begin
                        cmd_angle_next = angle_reg;
                        angle_next     = advanced;
                    end
                end
                PH_CHECK:
                begin
                    if (touch)
                    begin
                        done = 1'b1;
                        code = OUTCOME_TOP_TOUCH;
                    end
                    else
                    begin
                        phase_next = PH_SEARCH;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // Finish: return home and power down
        if (done)
        begin
            phase_next     = PH_IDLE;
            angle_next     = cfg.home_angle;
            cmd_angle_next = cfg.home_angle;
        end

        ctrl.clear  = fire && clear;
        ctrl.record = fire && record;
        ctrl.angle  = angle_reg;

        res.probe_angle = cmd_angle_next;
        res.servo_on    = (phase_next != PH_IDLE);
        res.done_res    = done;
        res.outcome     = done ? code : OUTCOME_MEASURED;
        res.level       = report ? stat.level : '0;
        res.spread      = report ? stat.spread : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            angle_reg     <= '0;
            cmd_angle_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            angle_reg     <= angle_next;
            cmd_angle_reg <= cmd_angle_next;
        end
    end

    `ASSERT_RST(a_idle_parked, (phase_reg == PH_IDLE) |-> (angle_reg == cmd_angle_reg),
        "idle probe not parked at commanded angle")
    `ASSERT_RST(a_done_powers_off, (fire && res.done_res) |=> (phase_reg == PH_IDLE),
        "finished measurement left sequencer running")

endmodule

@@ src/psl_out_buf.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psl_out_buf
// Result register with a skid stage; ready toward the core is registered.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module psl_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  psl_pkg::result_t  push_data,
    output logic              push_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output psl_pkg::result_t  out_data
);
    import psl_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop        = main_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            main_data_reg <= skid_data_reg;
        end
        else if (push && (pop || !main_valid_reg))
        begin
            main_data_reg <= push_data;
        end

        if (push && main_valid_reg && !pop)
        begin
            skid_data_reg <= push_data;
        end
    end

    `ASSERT_RST(a_skid_needs_main, skid_valid_reg |-> main_valid_reg,
        "skid entry held without a result in front")
    `ASSERT_RST(a_skid_on_stall, $rose(skid_valid_reg) |-> $past(main_valid_reg && !out_ready),
        "skid entry filled without a stalled result")

endmodule

@@ src/probe_sweep_level_measure.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// probe_sweep_level_measure
// Servo probe level measurement: wash sweep, back-off and repeated search
// sweeps; reports the mean touch angle and the max-min spread.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  item     in         valid / ready        func, adc_sample
//  result   out        valid / ready        probe_angle, servo_on, done_res,
//                                           outcome, level, spread
//  cfg      in         cfg_we (no stall)    cfg_index, cfg_data
//
//  One transaction per cycle sustained while the result side keeps up;
//  each accepted item passes through the input register, then through the
//  sequencer into the result register.
//  The result register has a skid stage, so ready toward the item side
//  comes from registers and a stalled result does not block the next item.
//  Reset is asynchronous and clears all control state and the statistics;
//  there is no memory and no clearing pass.
//  The critical path is the running-sum add followed by the reciprocal
//  multiply that forms the mean.
// ---------------------------------------------------------------------------
module probe_sweep_level_measure #(
    parameter int TOUCH_COUNT = psl_pkg::TOUCH_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    psl_item_if.sink                          item,
    psl_result_if.source                      result,
    input  logic                              cfg_we,
    input  logic [psl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [psl_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import psl_pkg::*;

    // Configuration registers
    cfg_t cfg_reg;

    // Input register
    logic             in_valid_reg;
    logic             func_reg;
    logic [ADC_W-1:0] sample_reg;

    logic        fire;
    logic        buf_ready;
    stats_ctrl_t stats_ctrl;
    stats_stat_t stats_stat;
    result_t     step_res;
    result_t     out_res;

    // Advance the held item when the result buffer has room
    assign fire       = in_valid_reg && buf_ready;
    assign item.ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.valid && item.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Capture payload on every accepted transaction
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            func_reg   <= item.func;
            sample_reg <= item.adc_sample;
        end
    end

    // Register writes act at once; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.home_angle      <= HOME_ANGLE_RST;
            cfg_reg.max_angle       <= MAX_ANGLE_RST;
            cfg_reg.wash_step       <= WASH_STEP_RST;
            cfg_reg.search_step     <= SEARCH_STEP_RST;
            cfg_reg.backoff_step    <= BACKOFF_STEP_RST;
            cfg_reg.touch_threshold <= TOUCH_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HOME_ANGLE:      cfg_reg.home_angle      <= cfg_data[ANGLE_W-1:0];
                REG_MAX_ANGLE:       cfg_reg.max_angle       <= cfg_data[ANGLE_W-1:0];
                REG_WASH_STEP:       cfg_reg.wash_step       <= cfg_data[STEP_W-1:0];
                REG_SEARCH_STEP:     cfg_reg.search_step     <= cfg_data[STEP_W-1:0];
                REG_BACKOFF_STEP:    cfg_reg.backoff_step    <= cfg_data[ANGLE_W-1:0];
                REG_TOUCH_THRESHOLD: cfg_reg.touch_threshold <= cfg_data[ADC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sweep sequencer
    psl_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .func       (func_reg),
        .adc_sample (sample_reg),
        .cfg        (cfg_reg),
        .stat       (stats_stat),
        .ctrl       (stats_ctrl),
        .res        (step_res)
    );

    // Touch statistics
    psl_stats #(
        .TOUCH_COUNT (TOUCH_COUNT)
    ) u_stats (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (stats_ctrl),
        .stat  (stats_stat)
    );

    // Result register and skid stage
    psl_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fire),
        .push_data  (step_res),
        .push_ready (buf_ready),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_data   (out_res)
    );

    assign result.probe_angle = out_res.probe_angle;
    assign result.servo_on    = out_res.servo_on;
    assign result.done_res    = out_res.done_res;
    assign result.outcome     = out_res.outcome;
    assign result.level       = out_res.level;
    assign result.spread      = out_res.spread;

endmodule
